>>> design/rbfcc_pkg.sv
package rbfcc_pkg;

    // reflected crc-32c polynomial
    localparam logic [31:0] CRC_POLY = 32'h82f6_3b78;
    localparam logic [31:0] CRC_INIT = 32'hffff_ffff;

    // header layout, byte offsets within a batch
    localparam logic [31:0] HDR_SIZE     = 32'd61;
    localparam logic [31:0] LEN_FIRST    = 32'd8;
    localparam logic [31:0] LEN_LAST     = 32'd11;
    localparam logic [31:0] MAGIC_POS    = 32'd16;
    localparam logic [31:0] CRC_FIRST    = 32'd17;
    localparam logic [31:0] CRC_LAST     = 32'd20;
    localparam logic [31:0] CRC_COVER    = 32'd21;
    localparam logic [31:0] ATTR_POS     = 32'd22;
    localparam logic [31:0] TS_FIRST     = 32'd27;
    localparam logic [31:0] TS_LAST      = 32'd34;
    localparam logic [31:0] CNT_FIRST    = 32'd57;
    localparam logic [31:0] CNT_LAST     = 32'd60;
    localparam logic [31:0] MIN_LENGTH   = HDR_SIZE - 32'd12;
    localparam logic [7:0]  MAGIC_V2     = 8'h02;
    localparam logic [2:0]  COMP_MASK    = 3'h7;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_INVALID     = 2'd1,
        ST_CRC         = 2'd2,
        ST_COMPRESSION = 2'd3
    } status_t;

    // one verdict as held in the result queue
    typedef struct packed {
        logic        is_final;
        status_t     status;
        logic [30:0] record_count;
        logic [63:0] batch_stamp;
        logic [30:0] batch_length;
    } result_t;

    // one byte of reflected crc-32c, bit at a time
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

>>> design/record_batch_frame_crc_checker_top.sv
// Record batch v2 header checker. Accepts one blob byte per clock on s_*,
// parses the 61-byte big-endian header of every batch, runs CRC-32C over
// bytes 21 to the batch end and returns a per-batch verdict on m_* at each
// batch end, plus a whole-blob verdict (m_tlast high) on the byte with
// s_tlast or on the first error. After an error the rest of the blob up to
// s_tlast is dropped silently. Each byte is parsed in the cycle it is
// accepted; its verdicts are written into a 4-entry result queue and leave
// it in order on m_*. s_tready is high while the queue has at least two free
// entries, so the block takes one byte per clock as long as results are
// drained; with m_tready held low it stops once fewer than two are free.
module record_batch_frame_crc_checker_top
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tlast,   // last_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // [30:0] record_count, [94:31] batch_stamp,
                                    // [125:95] batch_length, [127:126] zero
    output logic [1:0]   m_tuser,   // [1:0] status
    output logic         m_tlast    // is_final
);

    // batch parse state
    logic [31:0] pos_reg,   pos_next;
    logic [31:0] len_reg,   len_next;
    logic [31:0] chk_reg,   chk_next;
    logic [31:0] crc_reg,   crc_next;
    logic [2:0]  comp_reg,  comp_next;
    logic [31:0] cnt_reg,   cnt_next;
    logic [63:0] ts_reg,    ts_next;
    logic        failed_reg, failed_next;

    // result queue
    rbfcc_pkg::result_t res_q_reg [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg,  count_next;

    logic        accept;
    logic        pop;
    logic [1:0]  n_push;
    rbfcc_pkg::status_t st;
    rbfcc_pkg::status_t end_st;
    rbfcc_pkg::result_t res0, res1;

    // base values, reset to their start values at the first byte of a batch
    logic [31:0] len_b, chk_b, crc_b, cnt_b;
    logic [2:0]  comp_b;
    logic [63:0] ts_b;
    logic        bad_hdr;
    logic        at_end;
    logic [31:0] end_pos;

    assign accept   = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;
    assign s_tready = (count_reg <= 3'd2);

    // field capture for the current byte
    always_comb
    begin
        if (pos_reg == 32'd0)
        begin
            len_b  = 32'd0;
            chk_b  = 32'd0;
            crc_b  = rbfcc_pkg::CRC_INIT;
            comp_b = 3'd0;
            cnt_b  = 32'd0;
            ts_b   = 64'd0;
        end
        else
        begin
            len_b  = len_reg;
            chk_b  = chk_reg;
            crc_b  = crc_reg;
            comp_b = comp_reg;
            cnt_b  = cnt_reg;
            ts_b   = ts_reg;
        end

        len_next  = (pos_reg >= rbfcc_pkg::LEN_FIRST && pos_reg <= rbfcc_pkg::LEN_LAST)
                    ? {len_b[23:0], s_tdata} : len_b;
        chk_next  = (pos_reg >= rbfcc_pkg::CRC_FIRST && pos_reg <= rbfcc_pkg::CRC_LAST)
                    ? {chk_b[23:0], s_tdata} : chk_b;
        crc_next  = (pos_reg >= rbfcc_pkg::CRC_COVER)
                    ? rbfcc_pkg::crc_byte(crc_b, s_tdata) : crc_b;
        comp_next = (pos_reg == rbfcc_pkg::ATTR_POS)
                    ? (s_tdata[2:0] & rbfcc_pkg::COMP_MASK) : comp_b;
        ts_next   = (pos_reg >= rbfcc_pkg::TS_FIRST && pos_reg <= rbfcc_pkg::TS_LAST)
                    ? {ts_b[55:0], s_tdata} : ts_b;
        cnt_next  = (pos_reg >= rbfcc_pkg::CNT_FIRST && pos_reg <= rbfcc_pkg::CNT_LAST)
                    ? {cnt_b[23:0], s_tdata} : cnt_b;
    end

    // header checks and batch end verdict
    always_comb
    begin
        bad_hdr = ((pos_reg == rbfcc_pkg::LEN_LAST) &&
                   (len_next[31] || (len_next < rbfcc_pkg::MIN_LENGTH))) ||
                  ((pos_reg == rbfcc_pkg::MAGIC_POS) && (s_tdata != rbfcc_pkg::MAGIC_V2));
        end_pos = rbfcc_pkg::LEN_LAST + len_next;
        at_end  = (pos_reg >= rbfcc_pkg::LEN_LAST) && (pos_reg == end_pos);

        if ((crc_next ^ rbfcc_pkg::CRC_INIT) != chk_next)
            end_st = rbfcc_pkg::ST_CRC;
        else if (comp_next != 3'd0)
            end_st = rbfcc_pkg::ST_COMPRESSION;
        else if (cnt_next[31])
            end_st = rbfcc_pkg::ST_INVALID;
        else
            end_st = rbfcc_pkg::ST_OK;
    end

    // sequencing of batches and blobs
    always_comb
    begin
        pos_next    = pos_reg;
        failed_next = failed_reg;
        n_push      = 2'd0;
        st          = rbfcc_pkg::ST_OK;

        if (failed_reg)
        begin
            if (s_tlast)
            begin
                failed_next = 1'b0;
                pos_next    = 32'd0;
            end
        end
        else if (bad_hdr)
        begin
            st          = rbfcc_pkg::ST_INVALID;
            n_push      = 2'd2;
            pos_next    = 32'd0;
            failed_next = !s_tlast;
        end
        else if (at_end)
        begin
            st       = end_st;
            pos_next = 32'd0;
            if (end_st != rbfcc_pkg::ST_OK)
            begin
                n_push      = 2'd2;
                failed_next = !s_tlast;
            end
            else
            begin
                n_push = s_tlast ? 2'd2 : 2'd1;
            end
        end
        else if (s_tlast)
        begin
            st          = rbfcc_pkg::ST_INVALID;
            n_push      = 2'd2;
            pos_next    = 32'd0;
            failed_next = 1'b0;
        end
        else
        begin
            pos_next = pos_reg + 32'd1;
        end
    end

    // verdict payload
    always_comb
    begin
        res0.is_final       = 1'b0;
        res0.status         = st;
        res0.record_count   = (pos_reg >= rbfcc_pkg::CNT_LAST) ? cnt_next[30:0] : 31'd0;
        res0.batch_stamp    = (pos_reg >= rbfcc_pkg::TS_LAST) ? ts_next : 64'd0;
        res0.batch_length   = (pos_reg >= rbfcc_pkg::LEN_LAST) ? len_next[30:0] : 31'd0;
        res1                = res0;
        res1.is_final       = 1'b1;
    end

    assign count_next = count_reg + {1'b0, (accept ? n_push : 2'd0)} - {2'd0, pop};

    // parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 32'd0;
            len_reg    <= 32'd0;
            chk_reg    <= 32'd0;
            crc_reg    <= rbfcc_pkg::CRC_INIT;
            comp_reg   <= 3'd0;
            cnt_reg    <= 32'd0;
            ts_reg     <= 64'd0;
            failed_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg    <= pos_next;
            failed_reg <= failed_next;
            if (!failed_reg)
            begin
                len_reg  <= len_next;
                chk_reg  <= chk_next;
                crc_reg  <= crc_next;
                comp_reg <= comp_next;
                cnt_reg  <= cnt_next;
                ts_reg   <= ts_next;
            end
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                wr_ptr_reg <= wr_ptr_reg + n_push;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
        end
    end

    // queue storage, up to two verdicts per byte
    always_ff @(posedge clk)
    begin
        if (accept && (n_push != 2'd0))
        begin
            res_q_reg[wr_ptr_reg] <= res0;
        end
        if (accept && (n_push == 2'd2))
        begin
            res_q_reg[wr_ptr_reg + 2'd1] <= res1;
        end
    end

    // output beat
    assign m_tvalid = (count_reg != 3'd0);
    assign m_tlast  = res_q_reg[rd_ptr_reg].is_final;
    assign m_tuser  = res_q_reg[rd_ptr_reg].status;
    assign m_tdata  = {2'b00,
                       res_q_reg[rd_ptr_reg].batch_length,
                       res_q_reg[rd_ptr_reg].batch_stamp,
                       res_q_reg[rd_ptr_reg].record_count};

endmodule

>>> verif/record_batch_frame_crc_checker_top_test.sv
`timescale 1ns / 100ps

module record_batch_frame_crc_checker_top_test;

    import rbfcc_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int ITEM_TARGET  = 1950;
    localparam int HOLD_AT      = 700;
    localparam int HOLD_CYCLES  = 1000;

    // how the batch under test is damaged
    typedef enum logic [2:0] {
        F_NONE,
        F_CRC,
        F_MAGIC,
        F_LENGTH,
        F_NOISE
    } fault_t;

    // one blob: good batches first, then the batch under test, then loose bytes
    typedef struct {
        int          lead;
        fault_t      fault;
        int          area;
        logic [7:0]  attr;
        logic [63:0] stamp;
        logic [31:0] count;
        logic [31:0] forced;
        int          cut;
        int          tail;
        bit          pinned;
        status_t     want;
    } blob_spec_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         pinned;
        status_t    want;
    } beat_t;

    typedef struct {
        result_t res;
        bit      pinned;
        status_t want;
    } verdict_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'h00;   // [7:0] data_byte
    logic         s_tlast = 1'b0;    // last_byte
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;           // [30:0] record_count, [94:31] batch_stamp,
                                     // [125:95] batch_length, [127:126] zero
    logic [1:0]   m_tuser;           // [1:0] status
    logic         m_tlast;           // is_final

    beat_t    stim_q[$];
    verdict_t verdict_q[$];
    beat_t    offer = '{8'h00, 1'b0, 1'b0, ST_OK};
    verdict_t head;
    bit       offering = 1'b0;
    int       burst_left = 0;
    int       gap_left = 0;
    int       bytes_in = 0;
    int       mismatches = 0;
    int       cycle_count = 0;
    int       bytes_built = 0;

    // receiver state
    int       hold_left = 0;
    bit       hold_done = 1'b0;
    int       mode = 0;
    int       mode_left = 0;
    int       ready_phase = 0;
    logic     ready_next;

    // checker state of the expected-verdict model
    logic [31:0] at_byte = 32'd0;
    logic [31:0] len_word = 32'd0;
    logic [31:0] crc_word = 32'd0;
    logic [31:0] crc_acc = CRC_INIT;
    logic [2:0]  comp_code = 3'd0;
    logic [31:0] count_word = 32'd0;
    logic [63:0] stamp_word = 64'd0;
    bit          draining = 1'b0;

    blob_spec_t directed_rows [0:23] = '{
        // minimum length, all fields zero
        '{0, F_NONE,     0, 8'h00, 64'h0, 32'h0, 32'h0, -1, 0, 1, ST_OK},
        // largest count, timestamp all ones, high attribute bits only
        '{0, F_NONE,     5, 8'hf8, 64'hffff_ffff_ffff_ffff, 32'h7fff_ffff, 32'h0,
            -1, 0, 1, ST_OK},
        // three batches in one blob
        '{2, F_NONE,     3, 8'h00, 64'h8000_0000_0000_0000, 32'h1, 32'h0, -1, 0, 1, ST_OK},
        '{0, F_NONE,    20, 8'h00, 64'h7fff_ffff_ffff_ffff, 32'h7fff_fffe, 32'h0,
            -1, 0, 1, ST_OK},
        '{0, F_CRC,      4, 8'h00, 64'h1234, 32'h5, 32'h0, -1, 0, 1, ST_CRC},
        '{0, F_NONE,     4, 8'h07, 64'h1234, 32'h5, 32'h0, -1, 0, 1, ST_COMPRESSION},
        // crc mismatch wins over compression
        '{0, F_CRC,      4, 8'h01, 64'h1234, 32'h5, 32'h0, -1, 0, 1, ST_CRC},
        // negative count
        '{0, F_NONE,     4, 8'h00, 64'h1, 32'h8000_0000, 32'h0, -1, 0, 1, ST_INVALID},
        // compression wins over negative count
        '{0, F_NONE,     4, 8'h04, 64'h1, 32'hffff_ffff, 32'h0, -1, 0, 1, ST_COMPRESSION},
        '{0, F_CRC,      2, 8'h00, 64'h1, 32'h8000_0000, 32'h0, -1, 0, 1, ST_CRC},
        // bad magic on the last byte
        '{0, F_MAGIC,    4, 8'h00, 64'h0, 32'h0, 32'h01, 16, 0, 1, ST_INVALID},
        // bad magic, rest of blob dropped
        '{1, F_MAGIC,    4, 8'h00, 64'h0, 32'h0, 32'hff, 40, 3, 1, ST_INVALID},
        '{0, F_MAGIC,    4, 8'h00, 64'h0, 32'h0, 32'h00, -1, 0, 1, ST_INVALID},
        // length one below minimum
        '{0, F_LENGTH,   4, 8'h00, 64'h0, 32'h0, 32'd48, 11, 0, 1, ST_INVALID},
        '{1, F_LENGTH,   4, 8'h00, 64'h0, 32'h0, 32'd0, -1, 0, 1, ST_INVALID},
        // length with top bit set
        '{0, F_LENGTH,   4, 8'h00, 64'h0, 32'h0, 32'hffff_ffff, 11, 0, 1, ST_INVALID},
        '{0, F_LENGTH,   4, 8'h00, 64'h0, 32'h0, 32'h8000_0000, 20, 2, 1, ST_INVALID},
        // truncation: single byte, inside timestamp, inside count
        '{0, F_NONE,     4, 8'h00, 64'h55, 32'h3, 32'h0, 0, 0, 1, ST_INVALID},
        '{0, F_NONE,     4, 8'h00, 64'h55, 32'h3, 32'h0, 33, 0, 1, ST_INVALID},
        '{0, F_NONE,     4, 8'h00, 64'h55, 32'h3, 32'h0, 59, 0, 1, ST_INVALID},
        // good batch, then a second batch cut short
        '{0, F_NONE,     0, 8'h00, 64'h9, 32'h2, 32'h0, -1, 5, 1, ST_INVALID},
        '{0, F_CRC,      6, 8'h00, 64'h9, 32'h2, 32'h0, -1, 10, 1, ST_CRC},
        '{1, F_NONE,     7, 8'h30, 64'hdead_beef_0bad_f00d, 32'h1234_5678, 32'h0,
            -1, 0, 0, ST_OK},
        // largest legal length, blob ends long before it
        '{0, F_LENGTH,  30, 8'h00, 64'h0, 32'h0, 32'h7fff_ffff, 80, 0, 1, ST_INVALID}
    };

    record_batch_frame_crc_checker_top DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // crc-32c, reflected, one input bit per step
    function automatic logic [31:0] crc32c_next(logic [31:0] acc, logic [7:0] b);
        logic [31:0] c;
        c = acc;
        for (int i = 0; i < 8; i++)
        begin
            if (c[0] ^ b[i])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic void put_be(ref logic [7:0] bb[$], input int at,
                                   input logic [63:0] v, input int n);
        for (int k = 0; k < n; k++)
            bb[at + k] = v[8 * (n - 1 - k) +: 8];
    endfunction

    // one complete batch with its header filled in and a matching crc, one bit flipped for F_CRC
    function automatic void make_batch(ref logic [7:0] bb[$], input fault_t fault,
                                       input int area, input logic [7:0] attr,
                                       input logic [63:0] stamp, input logic [31:0] count,
                                       input logic [31:0] forced);
        logic [31:0] acc;
        logic [31:0] len;
        bb.delete();
        repeat (HDR_SIZE + area)
            bb.insert(bb.size(), 8'($urandom));
        len = (fault == F_LENGTH) ? forced : MIN_LENGTH + area;
        put_be(bb, LEN_FIRST, len, 4);
        bb[MAGIC_POS] = (fault == F_MAGIC) ? forced[7:0] : MAGIC_V2;
        bb[ATTR_POS] = attr;
        put_be(bb, TS_FIRST, stamp, 8);
        put_be(bb, CNT_FIRST, count, 4);
        acc = CRC_INIT;
        for (int i = CRC_COVER; i < bb.size(); i++)
            acc = crc32c_next(acc, bb[i]);
        acc = ~acc;
        if (fault == F_CRC)
            acc ^= 32'h1 << $urandom_range(0, 31);
        put_be(bb, CRC_FIRST, acc, 4);
    endfunction

    // turn one blob into beats, last flag on its final byte
    function automatic void queue_blob(blob_spec_t s);
        logic [7:0] blob[$];
        logic [7:0] one[$];
        beat_t      bt;
        if (s.fault == F_NOISE)
        begin
            repeat (s.area)
                blob.insert(blob.size(), 8'($urandom));
        end
        else
        begin
            repeat (s.lead)
            begin
                make_batch(one, F_NONE, $urandom_range(0, 8), 8'($urandom) & 8'hf8,
                           {$urandom, $urandom}, {1'b0, 31'($urandom)}, 32'h0);
                foreach (one[i])
                    blob.insert(blob.size(), one[i]);
            end
            make_batch(one, s.fault, s.area, s.attr, s.stamp, s.count, s.forced);
            if (s.cut >= 0)
            begin
                while (one.size() > s.cut + 1)
                    void'(one.pop_back());
            end
            foreach (one[i])
                blob.insert(blob.size(), one[i]);
            repeat (s.tail)
                blob.insert(blob.size(), 8'($urandom));
        end
        foreach (blob[i])
        begin
            bt.data = blob[i];
            bt.last = (i == blob.size() - 1);
            bt.pinned = s.pinned;
            bt.want = s.want;
            stim_q.insert(stim_q.size(), bt);
        end
        bytes_built += blob.size();
    endfunction

    // mostly well-formed blobs, some damaged ones, some noise
    function automatic blob_spec_t random_spec();
        blob_spec_t s;
        int         pick;
        pick = $urandom_range(0, 99);
        s.lead = $urandom_range(0, 2);
        s.fault = F_NONE;
        s.area = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 120) : $urandom_range(0, 8);
        s.attr = 8'($urandom) & 8'hf8;
        s.stamp = {$urandom, $urandom};
        s.count = {1'b0, 31'($urandom)};
        s.forced = 32'h0;
        s.cut = -1;
        s.tail = 0;
        s.pinned = 1'b0;
        s.want = ST_OK;
        if (pick >= 90)
        begin
            s.fault = F_NOISE;
            s.area = $urandom_range(1, 80);
        end
        else if (pick >= 70)
        begin
            case ($urandom_range(0, 6))
                0: s.fault = F_CRC;
                1:
                begin
                    s.fault = F_MAGIC;
                    s.forced = 32'($urandom_range(3, 257)) & 32'hff;
                end
                2:
                begin
                    s.fault = F_LENGTH;
                    s.forced = $urandom_range(0, 48);
                end
                3:
                begin
                    s.fault = F_LENGTH;
                    s.forced = {1'b1, 31'($urandom)};
                end
                4: s.attr = s.attr | 8'($urandom_range(1, 7));
                5: s.count[31] = 1'b1;
                default: s.cut = $urandom_range(0, HDR_SIZE - 2 + s.area);
            endcase
            if ($urandom_range(0, 1) == 1)
                s.tail = $urandom_range(1, 20);
        end
        return s;
    endfunction

    function automatic void clear_batch();
        at_byte = 32'd0;
        len_word = 32'd0;
        crc_word = 32'd0;
        crc_acc = CRC_INIT;
        comp_code = 3'd0;
        count_word = 32'd0;
        stamp_word = 64'd0;
    endfunction

    function automatic void record_verdict(logic fin, status_t st, logic [31:0] p,
                                           bit pinned, status_t want);
        verdict_t v;
        v.res.is_final = fin;
        v.res.status = st;
        v.res.record_count = (p >= CNT_LAST) ? count_word[30:0] : 31'd0;
        v.res.batch_stamp = (p >= TS_LAST) ? stamp_word : 64'd0;
        v.res.batch_length = (p >= LEN_LAST) ? len_word[30:0] : 31'd0;
        v.pinned = pinned;
        v.want = want;
        verdict_q.insert(verdict_q.size(), v);
    endfunction

    // expected verdicts caused by one accepted blob byte
    function automatic void predict_byte(logic [7:0] b, logic last, bit pinned, status_t want);
        logic [31:0] p;
        status_t     st;
        bit          bad;
        if (draining)
        begin
            if (last)
            begin
                draining = 1'b0;
                clear_batch();
            end
            return;
        end
        p = at_byte;
        if (p == 0)
            clear_batch();
        if (p >= LEN_FIRST && p <= LEN_LAST)
            len_word = {len_word[23:0], b};
        if (p >= CRC_FIRST && p <= CRC_LAST)
            crc_word = {crc_word[23:0], b};
        if (p >= CRC_COVER)
            crc_acc = crc32c_next(crc_acc, b);
        if (p == ATTR_POS)
            comp_code = b[2:0] & COMP_MASK;
        if (p >= TS_FIRST && p <= TS_LAST)
            stamp_word = {stamp_word[55:0], b};
        if (p >= CNT_FIRST && p <= CNT_LAST)
            count_word = {count_word[23:0], b};

        bad = 1'b0;
        st = ST_OK;
        if ((p == LEN_LAST && (len_word[31] || len_word < MIN_LENGTH)) ||
            (p == MAGIC_POS && b != MAGIC_V2))
        begin
            st = ST_INVALID;
            bad = 1'b1;
        end
        else if (p >= LEN_LAST && p == LEN_LAST + len_word)
        begin
            if (~crc_acc != crc_word)
                st = ST_CRC;
            else if (comp_code != 3'd0)
                st = ST_COMPRESSION;
            else if (count_word[31])
                st = ST_INVALID;
            bad = (st != ST_OK);
            if (!bad)
            begin
                record_verdict(1'b0, ST_OK, p, pinned, want);
                at_byte = 32'd0;
                if (last)
                    record_verdict(1'b1, ST_OK, p, pinned, want);
                return;
            end
        end
        else if (last)
        begin
            st = ST_INVALID;
            bad = 1'b1;
        end

        if (bad)
        begin
            record_verdict(1'b0, st, p, pinned, want);
            record_verdict(1'b1, st, p, pinned, want);
            at_byte = 32'd0;
            draining = !last;
        end
        else
            at_byte = p + 32'd1;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // sender: bursts of beats with random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_byte(offer.data, offer.last, offer.pinned, offer.want);
                bytes_in++;
                offering = 1'b0;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 64);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            if (!offering)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (stim_q.size() > 0)
                begin
                    offer = stim_q.pop_front();
                    offering = 1'b1;
                end
            end
            s_tvalid <= offering;
            s_tdata <= offer.data;
            s_tlast <= offer.last;
        end
    end

    // receiver: one long hold-off, otherwise shifting stall patterns
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            ready_phase++;
            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else if (!hold_done && bytes_in >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                ready_next = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 200);
                end
                mode_left--;
                case (mode)
                    0: ready_next = 1'b1;
                    1: ready_next = (ready_phase % 3 == 0);
                    default: ready_next = 1'($urandom_range(0, 1));
                endcase
            end
            m_tready <= ready_next;
        end
    end

    // compare each verdict beat with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("verdict beat with none pending: final %0b status %0d",
                       m_tlast, m_tuser);
                mismatches++;
            end
            else
            begin
                head = verdict_q.pop_front();
                check_field("is_final", head.res.is_final, m_tlast);
                check_field("status", head.res.status, m_tuser);
                check_field("record_count", head.res.record_count, m_tdata[30:0]);
                check_field("batch_stamp", head.res.batch_stamp, m_tdata[94:31]);
                check_field("batch_length", head.res.batch_length, m_tdata[125:95]);
                if (head.pinned && head.res.is_final)
                    check_field("blob status", head.want, m_tuser);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // stimulus and end of run
    initial
    begin
        foreach (directed_rows[i])
            queue_blob(directed_rows[i]);
        while (bytes_built < ITEM_TARGET)
            queue_blob(random_spec());

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (stim_q.size() != 0 || s_tvalid || verdict_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
